>>> src/cal_pkg.sv
package cal_pkg;

  // Width of the result day distance (saturates at all ones)
  localparam int DIST_BITS = 21;

  // Widest year handled by the shared arithmetic helpers
  localparam int CALC_BITS = 16;

  // ceil(2^23 / 100): exact quotient by 100 for any value below 91180
  localparam int RECIP_SHIFT = 23;
  localparam logic [16:0] RECIP_100 = 17'd83887;

  // Date after reset
  localparam int RESET_YEAR = 1970;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_NEXT = 2'd1,
    CMD_PREV = 2'd2,
    CMD_CMP  = 2'd3
  } cal_cmd_t;

  // x * RECIP_100; quotient by 100 sits in [32:23], low bits flag divisibility
  function automatic logic [32:0] recip_prod(input logic [CALC_BITS-1:0] x);
    return 33'(x) * 33'(RECIP_100);
  endfunction

  function automatic logic [9:0] div100(input logic [CALC_BITS-1:0] x);
    logic [32:0] p;
    p = recip_prod(x);
    return p[32:RECIP_SHIFT];
  endfunction

  // Remainder zero leaves the fraction below 2^16; any nonzero remainder puts it above
  function automatic logic is_leap(input logic [CALC_BITS-1:0] y);
    logic [32:0] p;
    logic        by100;
    p     = recip_prod(y);
    by100 = (p[22:16] == 7'd0);
    return (y[1:0] == 2'b00) && (!by100 || (p[24:23] == 2'b00));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    return ((m == 4'd2) && leap) ? 5'd29 : month_len(m);
  endfunction

  // Days of the months before m in a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

>>> src/cal_if.sv
// Command channel
interface cal_req_if #(parameter int YEAR_BITS = 12);
  logic                 valid;
  logic                 ready;
  logic [1:0]           cmd;
  logic [4:0]           in_day;
  logic [3:0]           in_month;
  logic [YEAR_BITS-1:0] in_year;

  modport source(output valid, cmd, in_day, in_month, in_year, input ready);
  modport sink(input valid, cmd, in_day, in_month, in_year, output ready);
endinterface

// Result channel
interface cal_rsp_if #(parameter int YEAR_BITS = 12);
  logic                           valid;
  logic                           ready;
  logic [4:0]                     cur_day;
  logic [3:0]                     cur_month;
  logic [YEAR_BITS-1:0]           cur_year;
  logic                           leap_year;
  logic                           is_less;
  logic                           is_equal;
  logic                           is_greater;
  logic [cal_pkg::DIST_BITS-1:0]  day_distance;

  modport source(output valid, cur_day, cur_month, cur_year, leap_year, is_less, is_equal,
                 is_greater, day_distance, input ready);
  modport sink(input valid, cur_day, cur_month, cur_year, leap_year, is_less, is_equal,
               is_greater, day_distance, output ready);
endinterface

>>> src/cal_step.sv
// Next value of the stored date for one command
module cal_step #(
  parameter int YEAR_BITS = 12
) (
  input  cal_pkg::cal_cmd_t     cmd,
  input  logic [4:0]            gd,
  input  logic [3:0]            gm,
  input  logic [YEAR_BITS-1:0]  gy,
  input  logic [4:0]            day,
  input  logic [3:0]            month,
  input  logic [YEAR_BITS-1:0]  year,
  output logic [4:0]            day_next,
  output logic [3:0]            month_next,
  output logic [YEAR_BITS-1:0]  year_next
);

  logic       leap;
  logic [4:0] lim;
  logic [3:0] prev_month;

  assign leap       = cal_pkg::is_leap(cal_pkg::CALC_BITS'(year));
  assign lim        = cal_pkg::days_in(month, leap);
  assign prev_month = month - 4'd1;

  always_comb begin
    day_next   = day;
    month_next = month;
    year_next  = year;
    unique case (cmd)
      cal_pkg::CMD_LOAD: begin
        day_next   = gd;
        month_next = gm;
        year_next  = gy;
      end
      cal_pkg::CMD_NEXT: begin
        // roll day, then month, then year; hold at 31.12 of the top year
        priority if (day < lim) begin
          day_next = day + 5'd1;
        end else if (month < 4'd12) begin
          day_next   = 5'd1;
          month_next = month + 4'd1;
        end else if (year != {YEAR_BITS{1'b1}}) begin
          day_next   = 5'd1;
          month_next = 4'd1;
          year_next  = year + YEAR_BITS'(1);
        end else begin
          // last day of the top year: keep the date
        end
      end
      cal_pkg::CMD_PREV: begin
        // hold at 01.01.0001
        priority if (day > 5'd1) begin
          day_next = day - 5'd1;
        end else if (month > 4'd1) begin
          month_next = prev_month;
          day_next   = cal_pkg::days_in(prev_month, leap);
        end else if (year > YEAR_BITS'(1)) begin
          year_next  = year - YEAR_BITS'(1);
          month_next = 4'd12;
          day_next   = 5'd31;
        end else begin
          // first day of year one: keep the date
        end
      end
      cal_pkg::CMD_CMP: begin
      end
    endcase
  end

endmodule

>>> src/calendar_date_counter_unit.sv
// Gregorian date counter. Holds one date (reset 01.01.1970) and takes one command beat per
// clock while ready is high: load, next day, previous day or compare only. Each command
// returns one result beat with the stored date after the command, its leap flag,
// less/equal/greater against the given (clamped) date and the absolute day distance. The
// stored date is updated by the combinational step logic as the command leaves stage 1, so
// back-to-back commands see each other's effect in order. Five internal stages plus the
// result register give buffering; ready drops only once they are all full.
// Invalid given dates are clamped: month to 1..12, year 0 to 1, day to 1..end of month.
module calendar_date_counter_unit #(
  parameter int YEAR_BITS = 12
) (
  input  logic       clk,
  input  logic       rst,
  cal_req_if.sink    req,
  cal_rsp_if.source  rsp
);

  localparam int DN_BITS  = YEAR_BITS + 9;
  localparam int SAT_BITS = (DN_BITS > cal_pkg::DIST_BITS) ? DN_BITS : cal_pkg::DIST_BITS + 1;
  localparam logic [YEAR_BITS-1:0] YEAR_RESET = YEAR_BITS'(cal_pkg::RESET_YEAR);

  // Stage valids and enables
  logic v0, v1, v2, v3, v4;
  logic en0, en1, en2, en3, en4, en5;
  logic upd;

  assign en5 = !rsp.valid || rsp.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign req.ready = en0;
  assign upd = v1 && en2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (en0) v0 <= req.valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) rsp.valid <= v4;
    end
  end

  // Stage 0: input register
  cal_pkg::cal_cmd_t    s0_cmd;
  logic [4:0]           s0_day;
  logic [3:0]           s0_month;
  logic [YEAR_BITS-1:0] s0_year;

  always_ff @(posedge clk) begin
    if (en0) begin
      s0_cmd   <= cal_pkg::cal_cmd_t'(req.cmd);
      s0_day   <= req.in_day;
      s0_month <= req.in_month;
      s0_year  <= req.in_year;
    end
  end

  // Clamp the given date
  logic [3:0]           c_month;
  logic [YEAR_BITS-1:0] c_year;
  logic [4:0]           c_lim;
  logic [4:0]           c_day;

  always_comb begin
    c_month = s0_month;
    if (s0_month == 4'd0) c_month = 4'd1;
    else if (s0_month > 4'd12) c_month = 4'd12;
    c_year = (s0_year == '0) ? YEAR_BITS'(1) : s0_year;
    c_lim  = cal_pkg::days_in(c_month, cal_pkg::is_leap(cal_pkg::CALC_BITS'(c_year)));
    c_day  = s0_day;
    if (s0_day == 5'd0) c_day = 5'd1;
    else if (s0_day > c_lim) c_day = c_lim;
  end

  // Stage 1: clamped command
  cal_pkg::cal_cmd_t    s1_cmd;
  logic [4:0]           s1_day;
  logic [3:0]           s1_month;
  logic [YEAR_BITS-1:0] s1_year;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_cmd   <= s0_cmd;
      s1_day   <= c_day;
      s1_month <= c_month;
      s1_year  <= c_year;
    end
  end

  // Stored date and its step logic
  logic [4:0]           date_day, date_day_next;
  logic [3:0]           date_month, date_month_next;
  logic [YEAR_BITS-1:0] date_year, date_year_next;

  cal_step #(.YEAR_BITS(YEAR_BITS)) u_step (
    .cmd        (s1_cmd),
    .gd         (s1_day),
    .gm         (s1_month),
    .gy         (s1_year),
    .day        (date_day),
    .month      (date_month),
    .year       (date_year),
    .day_next   (date_day_next),
    .month_next (date_month_next),
    .year_next  (date_year_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      date_day   <= 5'd1;
      date_month <= 4'd1;
      date_year  <= YEAR_RESET;
    end else if (upd) begin
      date_day   <= date_day_next;
      date_month <= date_month_next;
      date_year  <= date_year_next;
    end
  end

  // Stage 2: entry 0 is the stored date, entry 1 the given date
  logic [4:0]           s2_day   [2];
  logic [3:0]           s2_month [2];
  logic [YEAR_BITS-1:0] s2_year  [2];

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_day[0]   <= date_day_next;
      s2_month[0] <= date_month_next;
      s2_year[0]  <= date_year_next;
      s2_day[1]   <= s1_day;
      s2_month[1] <= s1_month;
      s2_year[1]  <= s1_year;
    end
  end

  // Year terms and month/day offset of each day number
  logic [YEAR_BITS-1:0] p_n    [2];
  logic                 p_leap [2];
  logic [DN_BITS-1:0]   p_yb   [2];
  logic [9:0]           p_q    [2];
  logic [8:0]           p_md   [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      p_n[i]    = s2_year[i] - YEAR_BITS'(1);
      p_leap[i] = cal_pkg::is_leap(cal_pkg::CALC_BITS'(s2_year[i]));
      p_yb[i]   = DN_BITS'(p_n[i]) * DN_BITS'(365) + DN_BITS'(p_n[i] >> 2);
      p_q[i]    = cal_pkg::div100(cal_pkg::CALC_BITS'(p_n[i]));
      p_md[i]   = cal_pkg::days_before(s2_month[i])
                + 9'(p_leap[i] && (s2_month[i] > 4'd2)) + 9'(s2_day[i]);
    end
  end

  // Stage 3
  logic [DN_BITS-1:0]   s3_yb [2];
  logic [9:0]           s3_q  [2];
  logic [8:0]           s3_md [2];
  logic [4:0]           s3_day;
  logic [3:0]           s3_month;
  logic [YEAR_BITS-1:0] s3_year;
  logic                 s3_leap;

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < 2; i++) begin
        s3_yb[i] <= p_yb[i];
        s3_q[i]  <= p_q[i];
        s3_md[i] <= p_md[i];
      end
      s3_day   <= s2_day[0];
      s3_month <= s2_month[0];
      s3_year  <= s2_year[0];
      s3_leap  <= p_leap[0];
    end
  end

  // Stage 4: day numbers
  logic [DN_BITS-1:0]   s4_dn [2];
  logic [4:0]           s4_day;
  logic [3:0]           s4_month;
  logic [YEAR_BITS-1:0] s4_year;
  logic                 s4_leap;

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int i = 0; i < 2; i++) begin
        s4_dn[i] <= s3_yb[i] - DN_BITS'(s3_q[i]) + DN_BITS'(s3_q[i] >> 2)
                  + DN_BITS'(s3_md[i]);
      end
      s4_day   <= s3_day;
      s4_month <= s3_month;
      s4_year  <= s3_year;
      s4_leap  <= s3_leap;
    end
  end

  // Compare and distance
  logic                 f_less, f_greater;
  logic [DN_BITS-1:0]   f_dist;
  logic [SAT_BITS-1:0]  f_dist_w;
  logic [cal_pkg::DIST_BITS-1:0] f_dist_sat;

  always_comb begin
    f_less     = s4_dn[0] < s4_dn[1];
    f_greater  = s4_dn[0] > s4_dn[1];
    f_dist     = f_greater ? (s4_dn[0] - s4_dn[1]) : (s4_dn[1] - s4_dn[0]);
    f_dist_w   = SAT_BITS'(f_dist);
    f_dist_sat = (f_dist_w > SAT_BITS'({cal_pkg::DIST_BITS{1'b1}}))
               ? {cal_pkg::DIST_BITS{1'b1}} : f_dist_w[cal_pkg::DIST_BITS-1:0];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (en5) begin
      rsp.cur_day      <= s4_day;
      rsp.cur_month    <= s4_month;
      rsp.cur_year     <= s4_year;
      rsp.leap_year    <= s4_leap;
      rsp.is_less      <= f_less;
      rsp.is_equal     <= !f_less && !f_greater;
      rsp.is_greater   <= f_greater;
      rsp.day_distance <= f_dist_sat;
    end
  end

  // Checks
  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> $onehot({rsp.is_less, rsp.is_equal, rsp.is_greater}))
    else $error("compare flags not one-hot");

  a_equal_dist: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.is_equal == (rsp.day_distance == '0)))
    else $error("equal flag disagrees with distance");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    (date_day != 5'd0) && (date_month != 4'd0) && (date_month <= 4'd12))
    else $error("stored date out of range");

  a_date_hold: assert property (@(posedge clk) disable iff (rst)
    (!upd || (s1_cmd == cal_pkg::CMD_CMP)) |=>
      ($stable(date_day) && $stable(date_month) && $stable(date_year)))
    else $error("stored date changed without a step or load");

endmodule
